[design/crc_keyed_message_dedup_store_top_assert.svh]
// assertion macros used by the dedup store back end
`ifndef CRC_KEYED_MESSAGE_DEDUP_STORE_TOP_ASSERT_SVH
`define CRC_KEYED_MESSAGE_DEDUP_STORE_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define CDDS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define CDDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cdds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdds_pkg
// shared types, constants and helper functions of the crc dedup store
// ----------------------------------------------------------------------------
package cdds_pkg;

    localparam int SLOTS       = 16;
    localparam int MAX_PAYLOAD = 256;

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int COUNT_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int MEM_DEPTH = SLOTS * MAX_PAYLOAD;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 32;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 4;
    localparam int IDX_EXT_W = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [STAT_W-1:0] {
        ST_ACK     = 2'd0,
        ST_SEEN    = 2'd1,
        ST_NOMEM   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_COMPARE,
        BK_COMMIT
    } back_state_t;

    // one finished message handed from front to back
    typedef struct packed {
        logic               invalid;
        logic [CRC_W-1:0]   id;
        logic [COUNT_W-1:0] len;
    } req_t;

    // back end status seen by the front end
    typedef struct packed {
        logic             pending;
        logic [SLOTS-1:0] used;
    } back_stat_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } pick_t;

    // reflected crc-32 update by one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // lowest set bit of a slot vector
    function automatic pick_t find_first(input logic [SLOTS-1:0] vec);
        pick_t r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                r.found = 1'b1;
                r.idx   = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    // slot number reported modulo 16
    function automatic logic [IDX_W-1:0] to_index(input logic [SLOT_W-1:0] idx);
        logic [IDX_EXT_W-1:0] wide;
        wide = IDX_EXT_W'(idx);
        return wide[IDX_W-1:0];
    endfunction

endpackage

[design/cdds_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdds_in_if
// byte stream channel into the dedup store
// ----------------------------------------------------------------------------
interface cdds_in_if;
    import cdds_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              byte_present;
    logic              last_byte;

    modport source (output valid, output payload_byte, output byte_present,
                    output last_byte, input ready);
    modport sink   (input valid, input payload_byte, input byte_present,
                    input last_byte, output ready);
endinterface

[design/cdds_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdds_out_if
// result channel out of the dedup store
// ----------------------------------------------------------------------------
interface cdds_out_if;
    import cdds_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [CRC_W-1:0]  message_id;
    logic [IDX_W-1:0]  slot_index;

    modport source (output valid, output status, output message_id,
                    output slot_index, input ready);
    modport sink   (input valid, input status, input message_id,
                    input slot_index, output ready);
endinterface

[design/cdds_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdds_front
// takes message bytes, runs the crc, stores payload, emits message requests
// ----------------------------------------------------------------------------
module cdds_front (
    input  logic                 clk,
    input  logic                 rst_n,
    cdds_in_if.sink              msg,
    input  cdds_pkg::back_stat_t stat,
    input  logic                 req_full,
    output logic                 req_push,
    output cdds_pkg::req_t       req
);
    import cdds_pkg::*;

    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;

    logic [CRC_W-1:0]   crc_upd;
    logic [COUNT_W-1:0] count_upd;
    logic               ovf_upd;
    logic               in_range;
    logic               accept;
    pick_t              free_slot;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;

    logic [BYTE_W-1:0]  payload_mem [MEM_DEPTH];

    // hold off while the back end still owns slot state
    assign msg.ready = !stat.pending && !req_full;
    assign accept    = msg.valid && msg.ready;

    always_comb
    begin
        in_range  = (count_reg < COUNT_W'(MAX_PAYLOAD));
        crc_upd   = msg.byte_present ? crc_byte(crc_reg, msg.payload_byte) : crc_reg;
        count_upd = (msg.byte_present && in_range) ? count_reg + COUNT_W'(1) : count_reg;
        ovf_upd   = ovf_reg | (msg.byte_present && !in_range);
        free_slot = find_first(~stat.used);
        wr_en     = accept && msg.byte_present && in_range && free_slot.found;
        wr_addr   = ADDR_W'(free_slot.idx) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(count_reg);

        req.invalid = (count_upd == '0) || ovf_upd;
        req.id      = req.invalid ? '0 : ~crc_upd;
        req.len     = count_upd;
        req_push    = accept && msg.last_byte;

        crc_next   = crc_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            if (msg.last_byte) begin
                crc_next   = CRC_INIT;
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                crc_next   = crc_upd;
                count_next = count_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            payload_mem[wr_addr] <= msg.payload_byte;
        end
    end

endmodule

[design/cdds_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdds_queue
// short fifo of finished messages between front and back end
// ----------------------------------------------------------------------------
module cdds_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cdds_pkg::req_t push_data,
    input  logic           pop,
    output cdds_pkg::req_t pop_data,
    output logic           full,
    output logic           empty
);
    import cdds_pkg::*;

    req_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/cdds_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdds_back
// slot table: duplicate search, slot allocation and result register
// ----------------------------------------------------------------------------
`include "crc_keyed_message_dedup_store_top_assert.svh"

module cdds_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cdds_pkg::req_t        head,
    input  logic                  q_empty,
    output logic                  q_pop,
    output cdds_pkg::back_stat_t  stat,
    cdds_out_if.source            result
);
    import cdds_pkg::*;

    back_state_t        state_reg, state_next;
    req_t               cur_reg;
    logic [SLOTS-1:0]   match_reg, match_next;
    logic [SLOTS-1:0]   used_reg, used_next;
    logic [CRC_W-1:0]   slot_id_reg  [SLOTS];
    logic [COUNT_W-1:0] slot_len_reg [SLOTS];

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [CRC_W-1:0]   out_id_reg;
    logic [IDX_W-1:0]   out_idx_reg;

    pick_t              hit, free_slot;
    logic               load_cur, load_match, commit, store_fire;
    status_t            dec_status;
    logic [CRC_W-1:0]   dec_id;
    logic [SLOT_W-1:0]  dec_idx;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++) begin
            match_next[i] = used_reg[i] && (slot_id_reg[i] == cur_reg.id);
        end
    end

    // outcome of the message sitting in the commit step
    always_comb
    begin
        hit        = find_first(match_reg);
        free_slot  = find_first(~used_reg);
        dec_status = ST_NOMEM;
        dec_id     = cur_reg.id;
        dec_idx    = '0;
        if (cur_reg.invalid) begin
            dec_status = ST_INVALID;
            dec_id     = '0;
        end else if (hit.found) begin
            dec_status = ST_SEEN;
            dec_idx    = hit.idx;
        end else if (free_slot.found) begin
            dec_status = ST_ACK;
            dec_idx    = free_slot.idx;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_cur   = 1'b0;
        load_match = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    load_cur   = 1'b1;
                    state_next = BK_COMPARE;
                end
            end
            BK_COMPARE:
            begin
                load_match = 1'b1;
                state_next = BK_COMMIT;
            end
            BK_COMMIT:
            begin
                if (!out_valid_reg || result.ready) begin
                    commit     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        store_fire = commit && (dec_status == ST_ACK);

        used_next = used_reg;
        if (store_fire) begin
            used_next[dec_idx] = 1'b1;
        end

        if (commit) begin
            out_valid_next = 1'b1;
        end else if (result.ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_cur) begin
            cur_reg <= head;
        end
        if (load_match) begin
            match_reg <= match_next;
        end
        if (store_fire) begin
            slot_id_reg[dec_idx]  <= cur_reg.id;
            slot_len_reg[dec_idx] <= cur_reg.len;
        end
        if (commit) begin
            out_status_reg <= dec_status;
            out_id_reg     <= dec_id;
            out_idx_reg    <= to_index(dec_idx);
        end
    end

    assign stat.pending = (state_reg != BK_IDLE) || !q_empty;
    assign stat.used    = used_reg;

    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.message_id = out_id_reg;
    assign result.slot_index = out_idx_reg;

    `CDDS_ASSERT_NEXT(a_store_adds_one, store_fire,
        $countones(used_reg) == $past($countones(used_reg)) + 1,
        "ack did not mark exactly one new slot")
    `CDDS_ASSERT_NEXT(a_used_only_on_store, !store_fire,
        used_reg == $past(used_reg),
        "slot used marks changed without an ack")
    `CDDS_ASSERT_IMPLY(a_hit_is_live, (state_reg == BK_COMMIT) && hit.found,
        used_reg[hit.idx] && (slot_id_reg[hit.idx] == cur_reg.id),
        "duplicate hit points at a slot that does not hold the id")

endmodule

[design/crc_keyed_message_dedup_store_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_keyed_message_dedup_store_top
// crc-32 keyed message store that reports new, duplicate, full or bad messages
// ----------------------------------------------------------------------------
//
//  channel   dir  fields                                   one transaction
//  -------   ---  ---------------------------------------  ---------------------
//  msg       in   payload_byte, byte_present, last_byte    one message item
//  result    out  status, message_id, slot_index           one message outcome
//
//  cycles: one item per cycle inside a message; after the item that carries
//    last_byte the input holds off through queue pop, id compare against
//    all slots and commit while the slot table settles
//  the commit waits for the result register, so a result not taken adds
//    its wait to that hold-off; the next message's first item is still taken
//    while the result sits unclaimed
//  reset: asynchronous, sets the crc to CRC_INIT, clears the counters, queue and every slot used
//    mark at once; slot ids, lengths and payload bytes are left as they are
//
module crc_keyed_message_dedup_store_top (
    input  logic       clk,
    input  logic       rst_n,
    cdds_in_if.sink    msg,
    cdds_out_if.source result
);
    import cdds_pkg::*;

    // front to queue
    req_t       fr_req;
    logic       fr_push;

    // queue to back
    req_t       q_head;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;

    // back end status fed to the front end (used marks, work outstanding)
    back_stat_t bk_stat;

    // front end: crc per byte, byte counting, payload write into first free slot
    cdds_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .msg      (msg),
        .stat     (bk_stat),
        .req_full (q_full),
        .req_push (fr_push),
        .req      (fr_req)
    );

    // finished messages wait here for the slot table
    cdds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_push),
        .push_data (fr_req),
        .pop       (q_pop),
        .pop_data  (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back end: duplicate search, slot allocation, result register
    cdds_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .stat    (bk_stat),
        .result  (result)
    );

endmodule
